// ----- hdl/sta_pkg.sv -----
// ----------------------------------------------------------------------------
// sta_pkg
// Shared widths, stage counts, register codes and transaction types of the
// arrive steering pipeline.
// ----------------------------------------------------------------------------
package sta_pkg;

  localparam int unsigned ValueWidth  = 24;
  localparam int unsigned CfgWidth    = ValueWidth - 1;
  localparam int unsigned TttWidth    = 16;
  localparam int unsigned FracBits    = 8;
  localparam int unsigned IdxWidth    = 3;

  localparam int unsigned MagWidth    = ValueWidth + 1;
  localparam int unsigned DistWidth   = ValueWidth + 1;
  localparam int unsigned DistSqWidth = 2 * MagWidth;
  localparam int unsigned QuotWidth   = ValueWidth + FracBits;
  localparam int unsigned LenWidth    = QuotWidth + 1;
  localparam int unsigned LenSqWidth  = 2 * LenWidth;

  localparam int unsigned DistStages  = 3 + DistWidth;
  localparam int unsigned SpeedStages = 2 * CfgWidth + 3;
  localparam int unsigned AccelStages = 1 + QuotWidth;
  localparam int unsigned ClampStages = LenWidth + CfgWidth + 4;
  localparam int unsigned Latency     = DistStages + SpeedStages + AccelStages + ClampStages;

  localparam logic [CfgWidth-1:0] MaxSpeedReset   = CfgWidth'(25600);
  localparam logic [CfgWidth-1:0] MaxAccelReset   = CfgWidth'(2560);
  localparam logic [CfgWidth-1:0] StopRadiusReset = CfgWidth'(1280);
  localparam logic [CfgWidth-1:0] SlowRadiusReset = CfgWidth'(25600);
  localparam logic [TttWidth-1:0] TttReset        = TttWidth'(256);

  typedef enum logic [IdxWidth-1:0] {
    IdxMaxSpeed     = 3'd0,
    IdxMaxAccel     = 3'd1,
    IdxStopRadius   = 3'd2,
    IdxSlowRadius   = 3'd3,
    IdxTimeToTarget = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgWidth-1:0] max_speed;
    logic [CfgWidth-1:0] max_accel;
    logic [CfgWidth-1:0] stop_radius;
    logic [CfgWidth-1:0] slow_radius;
    logic [TttWidth-1:0] time_to_target;
  } cfg_t;

  typedef struct packed {
    logic                       valid;
    logic [1:0][ValueWidth-1:0] target;
    logic [1:0][ValueWidth-1:0] pos;
    logic [1:0][ValueWidth-1:0] vel;
  } in_t;

  typedef struct packed {
    logic                       valid;
    logic [1:0]                 neg;
    logic [1:0][MagWidth-1:0]   mag;
    logic [DistWidth-1:0]       dlen;
    logic [1:0][ValueWidth-1:0] vel;
  } dist_t;

  typedef struct packed {
    logic                       valid;
    logic                       stop_hit;
    logic [1:0]                 neg;
    logic [1:0][CfgWidth-1:0]   wv;
    logic [1:0][ValueWidth-1:0] vel;
  } speed_t;

  typedef struct packed {
    logic                      valid;
    logic                      stop_hit;
    logic [1:0]                neg;
    logic [1:0][QuotWidth-1:0] quot;
  } accel_t;

  typedef struct packed {
    logic                       valid;
    logic                       stop_hit;
    logic [1:0][ValueWidth-1:0] accel;
  } out_t;

endpackage

// ----- hdl/sta_dist.sv -----
// ----------------------------------------------------------------------------
// sta_dist
// Offset to the target, its squared length and a one-bit-per-stage square
// root giving the distance.
// ----------------------------------------------------------------------------
module sta_dist
  import sta_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  in_t   in_i,
  output dist_t out_o
);

  typedef struct packed {
    logic [1:0]                  neg;
    logic [1:0][MagWidth-1:0]    mag;
    logic [1:0][DistSqWidth-1:0] sq;
    logic [DistSqWidth-1:0]      rad;
    logic [DistWidth+1:0]        rem;
    logic [DistWidth-1:0]        root;
    logic [1:0][ValueWidth-1:0]  vel;
  } pipe_t;

  pipe_t                 pipe_d [DistStages];
  pipe_t                 pipe_q [DistStages];
  logic [DistStages-1:0] valid_q;

  for (genvar j = 0; j < DistStages; j++) begin : g_stage
    if (j == 0) begin : g_sub
      always_comb begin
        logic [MagWidth-1:0] diff;
        pipe_d[j]     = '0;
        pipe_d[j].vel = in_i.vel;
        for (int l = 0; l < 2; l++) begin
          diff = {in_i.target[l][ValueWidth-1], in_i.target[l]}
               - {in_i.pos[l][ValueWidth-1], in_i.pos[l]};
          pipe_d[j].neg[l] = diff[MagWidth-1];
          pipe_d[j].mag[l] = diff[MagWidth-1] ? (~diff + 1'b1) : diff;
        end
      end
    end else if (j == 1) begin : g_sq
      always_comb begin
        pipe_d[j] = pipe_q[j-1];
        for (int l = 0; l < 2; l++) begin
          pipe_d[j].sq[l] = pipe_q[j-1].mag[l] * pipe_q[j-1].mag[l];
        end
      end
    end else if (j == 2) begin : g_add
      always_comb begin
        pipe_d[j]      = pipe_q[j-1];
        pipe_d[j].rad  = pipe_q[j-1].sq[0] + pipe_q[j-1].sq[1];
        pipe_d[j].rem  = '0;
        pipe_d[j].root = '0;
      end
    end else begin : g_root
      always_comb begin
        logic [DistWidth+3:0] acc;
        logic [DistWidth+3:0] trial;
        logic [DistWidth+3:0] diff;
        pipe_d[j]     = pipe_q[j-1];
        acc           = {pipe_q[j-1].rem, pipe_q[j-1].rad[DistSqWidth-1 -: 2]};
        trial         = {2'b00, pipe_q[j-1].root, 2'b01};
        diff          = acc - trial;
        pipe_d[j].rad = {pipe_q[j-1].rad[DistSqWidth-3:0], 2'b00};
        if (acc >= trial) begin
          pipe_d[j].rem  = diff[DistWidth+1:0];
          pipe_d[j].root = {pipe_q[j-1].root[DistWidth-2:0], 1'b1};
        end else begin
          pipe_d[j].rem  = acc[DistWidth+1:0];
          pipe_d[j].root = {pipe_q[j-1].root[DistWidth-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[DistStages-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  assign out_o.valid = valid_q[DistStages-1];
  assign out_o.neg   = pipe_q[DistStages-1].neg;
  assign out_o.mag   = pipe_q[DistStages-1].mag;
  assign out_o.dlen  = pipe_q[DistStages-1].root;
  assign out_o.vel   = pipe_q[DistStages-1].vel;

endmodule

// ----- hdl/sta_speed.sv -----
// ----------------------------------------------------------------------------
// sta_speed
// Stop test, wanted speed and the wanted velocity along the offset, using
// restoring dividers that settle one quotient bit per stage.
// ----------------------------------------------------------------------------
module sta_speed
  import sta_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  dist_t  in_i,
  output speed_t out_o
);

  localparam int unsigned SelStage  = CfgWidth + 1;
  localparam int unsigned ProdStage = CfgWidth + 2;

  typedef struct packed {
    logic                       stop_hit;
    logic                       far;
    logic [1:0]                 neg;
    logic [1:0][MagWidth-1:0]   mag;
    logic [DistWidth-1:0]       dlen;
    logic [1:0][ValueWidth-1:0] vel;
    logic [CfgWidth-1:0]        spd;
    logic [1:0][DistWidth-1:0]  rem;
    logic [1:0][CfgWidth-1:0]   lo;
  } pipe_t;

  pipe_t                  pipe_d [SpeedStages];
  pipe_t                  pipe_q [SpeedStages];
  logic [SpeedStages-1:0] valid_q;

  for (genvar j = 0; j < SpeedStages; j++) begin : g_stage
    if (j == 0) begin : g_entry
      always_comb begin
        logic [CfgWidth+DistWidth-1:0] prod;
        pipe_d[j]          = '0;
        pipe_d[j].neg      = in_i.neg;
        pipe_d[j].mag      = in_i.mag;
        pipe_d[j].dlen     = in_i.dlen;
        pipe_d[j].vel      = in_i.vel;
        pipe_d[j].stop_hit = in_i.dlen < DistWidth'(cfg_i.stop_radius);
        pipe_d[j].far      = in_i.dlen > DistWidth'(cfg_i.slow_radius);
        prod               = cfg_i.max_speed * in_i.dlen;
        pipe_d[j].rem[0]   = prod[CfgWidth +: DistWidth];
        pipe_d[j].lo[0]    = prod[CfgWidth-1:0];
      end
    end else if (j < SelStage) begin : g_sdiv
      always_comb begin
        logic [DistWidth:0] acc;
        logic [DistWidth:0] dvs;
        logic [DistWidth:0] diff;
        pipe_d[j] = pipe_q[j-1];
        acc       = {pipe_q[j-1].rem[0], pipe_q[j-1].lo[0][CfgWidth-1]};
        dvs       = (DistWidth + 1)'(cfg_i.slow_radius);
        diff      = acc - dvs;
        pipe_d[j].rem[0] = (acc >= dvs) ? diff[DistWidth-1:0] : acc[DistWidth-1:0];
        pipe_d[j].lo[0]  = {pipe_q[j-1].lo[0][CfgWidth-2:0], acc >= dvs};
      end
    end else if (j == SelStage) begin : g_sel
      always_comb begin
        pipe_d[j] = pipe_q[j-1];
        if (pipe_q[j-1].far) begin
          pipe_d[j].spd = cfg_i.max_speed;
        end else if (cfg_i.slow_radius == '0) begin
          pipe_d[j].spd = '0;
        end else begin
          pipe_d[j].spd = pipe_q[j-1].lo[0];
        end
      end
    end else if (j == ProdStage) begin : g_prod
      always_comb begin
        logic [MagWidth+CfgWidth-1:0] prod;
        pipe_d[j] = pipe_q[j-1];
        for (int l = 0; l < 2; l++) begin
          prod             = pipe_q[j-1].mag[l] * pipe_q[j-1].spd;
          pipe_d[j].rem[l] = prod[CfgWidth +: DistWidth];
          pipe_d[j].lo[l]  = prod[CfgWidth-1:0];
        end
      end
    end else begin : g_vdiv
      always_comb begin
        logic [DistWidth:0] acc;
        logic [DistWidth:0] dvs;
        logic [DistWidth:0] diff;
        pipe_d[j] = pipe_q[j-1];
        dvs       = {1'b0, pipe_q[j-1].dlen};
        for (int l = 0; l < 2; l++) begin
          acc  = {pipe_q[j-1].rem[l], pipe_q[j-1].lo[l][CfgWidth-1]};
          diff = acc - dvs;
          pipe_d[j].rem[l] = (acc >= dvs) ? diff[DistWidth-1:0] : acc[DistWidth-1:0];
          pipe_d[j].lo[l]  = {pipe_q[j-1].lo[l][CfgWidth-2:0], acc >= dvs};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[SpeedStages-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  assign out_o.valid    = valid_q[SpeedStages-1];
  assign out_o.stop_hit = pipe_q[SpeedStages-1].stop_hit;
  assign out_o.neg      = pipe_q[SpeedStages-1].neg;
  assign out_o.vel      = pipe_q[SpeedStages-1].vel;
  assign out_o.wv       = (pipe_q[SpeedStages-1].dlen == '0) ? '0 : pipe_q[SpeedStages-1].lo;

endmodule

// ----- hdl/sta_accel.sv -----
// ----------------------------------------------------------------------------
// sta_accel
// Velocity error and its division by the time to target, one quotient bit
// per stage on both axes.
// ----------------------------------------------------------------------------
module sta_accel
  import sta_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  speed_t in_i,
  output accel_t out_o
);

  typedef struct packed {
    logic                      stop_hit;
    logic [1:0]                neg;
    logic [1:0][TttWidth-1:0]  rem;
    logic [1:0][QuotWidth-1:0] lo;
  } pipe_t;

  pipe_t                  pipe_d [AccelStages];
  pipe_t                  pipe_q [AccelStages];
  logic [AccelStages-1:0] valid_q;
  logic [TttWidth-1:0]    ttt;

  assign ttt = (cfg_i.time_to_target == '0) ? TttWidth'(1) : cfg_i.time_to_target;

  for (genvar j = 0; j < AccelStages; j++) begin : g_stage
    if (j == 0) begin : g_err
      always_comb begin
        logic [ValueWidth:0] wv;
        logic [ValueWidth:0] err;
        logic [ValueWidth:0] emag;
        pipe_d[j]          = '0;
        pipe_d[j].stop_hit = in_i.stop_hit;
        for (int l = 0; l < 2; l++) begin
          wv   = {2'b00, in_i.wv[l]};
          wv   = in_i.neg[l] ? (~wv + 1'b1) : wv;
          err  = wv - {in_i.vel[l][ValueWidth-1], in_i.vel[l]};
          emag = err[ValueWidth] ? (~err + 1'b1) : err;
          pipe_d[j].neg[l] = err[ValueWidth];
          pipe_d[j].lo[l]  = {emag[ValueWidth-1:0], {FracBits{1'b0}}};
        end
      end
    end else begin : g_div
      always_comb begin
        logic [TttWidth:0] acc;
        logic [TttWidth:0] diff;
        pipe_d[j] = pipe_q[j-1];
        for (int l = 0; l < 2; l++) begin
          acc  = {pipe_q[j-1].rem[l], pipe_q[j-1].lo[l][QuotWidth-1]};
          diff = acc - {1'b0, ttt};
          pipe_d[j].rem[l] = (acc >= {1'b0, ttt}) ? diff[TttWidth-1:0] : acc[TttWidth-1:0];
          pipe_d[j].lo[l]  = {pipe_q[j-1].lo[l][QuotWidth-2:0], acc >= {1'b0, ttt}};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[AccelStages-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  assign out_o.valid    = valid_q[AccelStages-1];
  assign out_o.stop_hit = pipe_q[AccelStages-1].stop_hit;
  assign out_o.neg      = pipe_q[AccelStages-1].neg;
  assign out_o.quot     = pipe_q[AccelStages-1].lo;

endmodule

// ----- hdl/sta_clamp.sv -----
// ----------------------------------------------------------------------------
// sta_clamp
// Length of the acceleration by a staged square root, rescaling to the
// maximum acceleration by staged division when the length exceeds it, and
// the signed result, forced to zero inside the stop radius.
module sta_clamp
  import sta_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  accel_t in_i,
  output out_t   out_o
);

  localparam int unsigned ProdStage = LenWidth + 2;
  localparam int unsigned LastStage = ClampStages - 1;

  typedef struct packed {
    logic                        stop_hit;
    logic                        over;
    logic [1:0]                  neg;
    logic [1:0][QuotWidth-1:0]   quot;
    logic [1:0][2*QuotWidth-1:0] sq;
    logic [LenSqWidth-1:0]       rad;
    logic [LenWidth+1:0]         srem;
    logic [LenWidth-1:0]         root;
    logic [1:0][LenWidth-1:0]    rem;
    logic [1:0][CfgWidth-1:0]    lo;
    logic [1:0][ValueWidth-1:0]  res;
  } pipe_t;

  pipe_t                  pipe_d [ClampStages];
  pipe_t                  pipe_q [ClampStages];
  logic [ClampStages-1:0] valid_q;

  for (genvar j = 0; j < ClampStages; j++) begin : g_stage
    if (j == 0) begin : g_sq
      always_comb begin
        pipe_d[j]          = '0;
        pipe_d[j].stop_hit = in_i.stop_hit;
        pipe_d[j].neg      = in_i.neg;
        pipe_d[j].quot     = in_i.quot;
        for (int l = 0; l < 2; l++) begin
          pipe_d[j].sq[l] = in_i.quot[l] * in_i.quot[l];
        end
      end
    end else if (j == 1) begin : g_add
      always_comb begin
        pipe_d[j]      = pipe_q[j-1];
        pipe_d[j].rad  = LenSqWidth'(pipe_q[j-1].sq[0]) + LenSqWidth'(pipe_q[j-1].sq[1]);
        pipe_d[j].srem = '0;
        pipe_d[j].root = '0;
      end
    end else if (j < ProdStage) begin : g_root
      always_comb begin
        logic [LenWidth+3:0] acc;
        logic [LenWidth+3:0] trial;
        logic [LenWidth+3:0] diff;
        pipe_d[j]     = pipe_q[j-1];
        acc           = {pipe_q[j-1].srem, pipe_q[j-1].rad[LenSqWidth-1 -: 2]};
        trial         = {2'b00, pipe_q[j-1].root, 2'b01};
        diff          = acc - trial;
        pipe_d[j].rad = {pipe_q[j-1].rad[LenSqWidth-3:0], 2'b00};
        if (acc >= trial) begin
          pipe_d[j].srem = diff[LenWidth+1:0];
          pipe_d[j].root = {pipe_q[j-1].root[LenWidth-2:0], 1'b1};
        end else begin
          pipe_d[j].srem = acc[LenWidth+1:0];
          pipe_d[j].root = {pipe_q[j-1].root[LenWidth-2:0], 1'b0};
        end
      end
    end else if (j == ProdStage) begin : g_prod
      always_comb begin
        logic [QuotWidth+CfgWidth-1:0] prod;
        pipe_d[j]      = pipe_q[j-1];
        pipe_d[j].over = pipe_q[j-1].root > LenWidth'(cfg_i.max_accel);
        for (int l = 0; l < 2; l++) begin
          prod             = pipe_q[j-1].quot[l] * cfg_i.max_accel;
          pipe_d[j].rem[l] = {1'b0, prod[CfgWidth +: QuotWidth]};
          pipe_d[j].lo[l]  = prod[CfgWidth-1:0];
        end
      end
    end else if (j < LastStage) begin : g_div
      always_comb begin
        logic [LenWidth:0] acc;
        logic [LenWidth:0] dvs;
        logic [LenWidth:0] diff;
        pipe_d[j] = pipe_q[j-1];
        dvs       = {1'b0, pipe_q[j-1].root};
        for (int l = 0; l < 2; l++) begin
          acc  = {pipe_q[j-1].rem[l], pipe_q[j-1].lo[l][CfgWidth-1]};
          diff = acc - dvs;
          pipe_d[j].rem[l] = (acc >= dvs) ? diff[LenWidth-1:0] : acc[LenWidth-1:0];
          pipe_d[j].lo[l]  = {pipe_q[j-1].lo[l][CfgWidth-2:0], acc >= dvs};
        end
      end
    end else begin : g_sign
      always_comb begin
        logic [ValueWidth-1:0] mag;
        pipe_d[j] = pipe_q[j-1];
        for (int l = 0; l < 2; l++) begin
          mag = pipe_q[j-1].over ? {1'b0, pipe_q[j-1].lo[l]}
                                 : {1'b0, pipe_q[j-1].quot[l][CfgWidth-1:0]};
          if (pipe_q[j-1].stop_hit) begin
            pipe_d[j].res[l] = '0;
          end else if (pipe_q[j-1].neg[l]) begin
            pipe_d[j].res[l] = ~mag + 1'b1;
          end else begin
            pipe_d[j].res[l] = mag;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[ClampStages-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  assign out_o.valid    = valid_q[LastStage];
  assign out_o.stop_hit = pipe_q[LastStage].stop_hit;
  assign out_o.accel    = pipe_q[LastStage].res;

endmodule

// ----- hdl/steer_arrive.sv -----
// ----------------------------------------------------------------------------
// steer_arrive
// Arrive steering: acceleration towards a target that slows the agent down
// inside the slow radius and is clamped to the maximum acceleration.
//
// Channel   Direction  Handshake                 Payload
// input     in         start, busy               target_x/y, pos_x/y, vel_x/y
// result    out        done_o (one-cycle strobe) accel_x/y, inside_stop
// config    in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One transaction enters every cycle; busy stays low.
// Each result passes through the distance, speed, acceleration and clamp stages,
// which hold the staged square roots and the one-bit-per-stage dividers.
// Reset clears the valid bits and loads the register reset values.
// Results are strobed for a single cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module steer_arrive
  import sta_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [ValueWidth-1:0] target_x_i,
  input  logic [ValueWidth-1:0] target_y_i,
  input  logic [ValueWidth-1:0] pos_x_i,
  input  logic [ValueWidth-1:0] pos_y_i,
  input  logic [ValueWidth-1:0] vel_x_i,
  input  logic [ValueWidth-1:0] vel_y_i,
  output logic                  done_o,
  output logic [ValueWidth-1:0] accel_x_o,
  output logic [ValueWidth-1:0] accel_y_o,
  output logic                  inside_stop_o,
  input  logic                  cfg_we_i,
  input  logic [IdxWidth-1:0]   cfg_idx_i,
  input  logic [CfgWidth-1:0]   cfg_wdata_i
);

  cfg_t   cfg_q;
  in_t    in_s;
  dist_t  dist_s;
  speed_t speed_s;
  accel_t accel_s;
  out_t   out_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_speed      <= MaxSpeedReset;
      cfg_q.max_accel      <= MaxAccelReset;
      cfg_q.stop_radius    <= StopRadiusReset;
      cfg_q.slow_radius    <= SlowRadiusReset;
      cfg_q.time_to_target <= TttReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        IdxMaxSpeed:     cfg_q.max_speed      <= cfg_wdata_i;
        IdxMaxAccel:     cfg_q.max_accel      <= cfg_wdata_i;
        IdxStopRadius:   cfg_q.stop_radius    <= cfg_wdata_i;
        IdxSlowRadius:   cfg_q.slow_radius    <= cfg_wdata_i;
        IdxTimeToTarget: cfg_q.time_to_target <= cfg_wdata_i[TttWidth-1:0];
        default: ;
      endcase
    end
  end

  assign busy          = 1'b0;
  assign in_s.valid    = start && !busy;
  assign in_s.target   = {target_y_i, target_x_i};
  assign in_s.pos      = {pos_y_i, pos_x_i};
  assign in_s.vel      = {vel_y_i, vel_x_i};

  sta_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_s),
    .out_o  (dist_s)
  );

  sta_speed u_speed (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (dist_s),
    .out_o  (speed_s)
  );

  sta_accel u_accel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (speed_s),
    .out_o  (accel_s)
  );

  sta_clamp u_clamp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (accel_s),
    .out_o  (out_s)
  );

  assign done_o        = out_s.valid;
  assign accel_x_o     = out_s.accel[0];
  assign accel_y_o     = out_s.accel[1];
  assign inside_stop_o = out_s.stop_hit;

  // Every accepted transaction raises done_o once it has passed all pipeline stages.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##Latency done_o)
    else $error("transaction did not complete after the pipeline latency");

  a_stop_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && inside_stop_o |-> accel_x_o == '0 && accel_y_o == '0)
    else $error("non-zero acceleration inside the stop radius");

  a_clamp_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accel_s.valid, ClampStages))
    else $error("result strobe without a matching clamp stage entry");

endmodule
